### sv/hhdd_pkg.sv
// shared types, constants and register codes of the heading hold controller
package hhdd_pkg;

    // behavior constants
    localparam int SLEW_STEP   = 1;
    localparam int DEADBAND    = 2;
    localparam int FILT_KEEP   = 179;
    localparam int FILT_TAKE   = 77;
    localparam int DECAY_MUL   = 179;
    // 130/100 reduced to 13/10, divide by 10 as multiply by ceil(2^16/10)
    localparam int LEFT_NUM    = 13;
    localparam int RECIP_10    = 6554;
    localparam int LEFT_BIAS   = 3;
    localparam int WRAP_Q8     = 360 * 256 + 128;
    localparam int HALF_Q8     = 128;
    localparam int IGNORE_INIT = 40;

    // channel widths
    localparam int YAW_W      = 17;
    localparam int LINE_W     = 8;
    localparam int DRIVE_W    = 11;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;
    localparam int IGN_W      = 16;

    // shared multiplier widths
    localparam int MUL_A_W = 24;
    localparam int MUL_B_W = 14;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TARGET = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BASE   = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IGNORE = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT  = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_P = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_I = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_D = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_PID_MAX = 4'd7;

    typedef logic signed [YAW_W-1:0]   t_yaw;
    typedef logic [LINE_W-1:0]         t_line;
    typedef logic signed [DRIVE_W-1:0] t_drive;
    typedef logic [CFG_IDX_W-1:0]      t_cfg_idx;
    typedef logic [CFG_DATA_W-1:0]     t_cfg_data;
    typedef logic signed [MUL_A_W-1:0] t_mul_a;
    typedef logic signed [MUL_B_W-1:0] t_mul_b;
    typedef logic signed [MUL_P_W-1:0] t_mul_p;

    typedef struct packed {
        logic [8:0] target_heading;
        logic [7:0] base_speed;
        logic [9:0] drive_limit;
        logic [9:0] gain_p;
        logic [9:0] gain_i;
        logic [9:0] gain_d;
        logic [6:0] pid_max;
    } t_cfg;

    typedef struct packed {
        logic             load;
        logic [IGN_W-1:0] value;
    } t_ign_load;

endpackage

### sv/hhdd_ifc.sv
// valid/ready channel interfaces: sample in, drive word out, register write
interface hhdd_in_if;
    import hhdd_pkg::*;
    logic  valid;
    logic  ready;
    t_yaw  yaw_angle;
    logic  yaw_valid;
    t_line line_bits;
    modport source (output valid, output yaw_angle, output yaw_valid, output line_bits,
                    input ready);
    modport sink (input valid, input yaw_angle, input yaw_valid, input line_bits,
                  output ready);
endinterface

interface hhdd_out_if;
    import hhdd_pkg::*;
    logic   valid;
    logic   ready;
    t_drive left_drive;
    t_drive right_drive;
    logic   stopped;
    logic   alert_start;
    modport source (output valid, output left_drive, output right_drive, output stopped,
                    output alert_start, input ready);
    modport sink (input valid, input left_drive, input right_drive, input stopped,
                  input alert_start, output ready);
endinterface

interface hhdd_cfg_if;
    import hhdd_pkg::*;
    logic      valid;
    logic      ready;
    t_cfg_idx  index;
    t_cfg_data data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

### sv/hhdd_mul.sv
// shared signed multiplier with registered product
module hhdd_mul (
    input  logic            i_clk,
    input  hhdd_pkg::t_mul_a i_a,
    input  hhdd_pkg::t_mul_b i_b,
    output hhdd_pkg::t_mul_p o_p
);
    import hhdd_pkg::*;

    t_mul_p r_p;

    always_ff @(posedge i_clk) begin
        r_p <= MUL_P_W'(i_a) * MUL_P_W'(i_b);
    end

    assign o_p = r_p;

endmodule

### sv/hhdd_cfg_regs.sv
// configuration register file and ignore count load strobe
module hhdd_cfg_regs (
    input  logic                i_clk,
    input  logic                i_rst_n,
    hhdd_cfg_if.sink            i_cfg,
    output hhdd_pkg::t_cfg      o_cfg,
    output hhdd_pkg::t_ign_load o_ign_load
);
    import hhdd_pkg::*;

    t_cfg r_cfg;
    logic wr;

    assign i_cfg.ready = 1'b1;
    assign wr = i_cfg.valid && i_cfg.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.target_heading <= 9'd0;
            r_cfg.base_speed     <= 8'd30;
            r_cfg.drive_limit    <= 10'd100;
            r_cfg.gain_p         <= 10'd46;
            r_cfg.gain_i         <= 10'd0;
            r_cfg.gain_d         <= 10'd77;
            r_cfg.pid_max        <= 7'd12;
        end else if (wr) begin
            case (i_cfg.index)
                REG_TARGET:  r_cfg.target_heading <= i_cfg.data[8:0];
                REG_BASE:    r_cfg.base_speed     <= i_cfg.data[7:0];
                REG_LIMIT:   r_cfg.drive_limit    <= i_cfg.data[9:0];
                REG_GAIN_P:  r_cfg.gain_p         <= i_cfg.data[9:0];
                REG_GAIN_I:  r_cfg.gain_i         <= i_cfg.data[9:0];
                REG_GAIN_D:  r_cfg.gain_d         <= i_cfg.data[9:0];
                REG_PID_MAX: r_cfg.pid_max        <= i_cfg.data[6:0];
                default: begin
                end
            endcase
        end
    end

    // ignore ticks only ever reload the live count
    assign o_ign_load.load  = wr && (i_cfg.index == REG_IGNORE);
    assign o_ign_load.value = i_cfg.data[IGN_W-1:0];
    assign o_cfg = r_cfg;

endmodule

### sv/heading_hold_differential_drive.sv
// heading hold controller top: sequencer, controller state and output word register
//
//  channel  | dir | fields                                        | accepted when
//  ---------+-----+-----------------------------------------------+--------------------
//  i_in     | in  | yaw_angle(17s) yaw_valid(1) line_bits(8)      | valid && ready
//  o_out    | out | left_drive(11s) right_drive(11s) stopped alert | valid && ready
//  i_cfg    | in  | index(4) data(16), registers 0..7              | valid && ready
//
//  a tick word is taken only in idle; a steering tick then runs its steps through
//  one shared multiplier (filter, three pid terms, decay, left wheel scaling),
//  so no new word is taken until the tick is through its last step
//  a word with the stop latched or the end line just seen skips from idle to the last step
//  a word with yaw_valid low is dropped in its accept cycle and changes nothing
//  reset is synchronous; the drive word waits in an output register, a stalled sink
//  only holds the sequencer in its last step when a second word is ready to go out
module heading_hold_differential_drive (
    input  logic     i_clk,
    input  logic     i_rst_n,
    hhdd_in_if.sink  i_in,
    hhdd_out_if.source o_out,
    hhdd_cfg_if.sink i_cfg
);
    import hhdd_pkg::*;

    // sequencer steps
    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_ERR   = 5'd1;
    localparam logic [4:0] S_FILT1 = 5'd2;
    localparam logic [4:0] S_FILT2 = 5'd3;
    localparam logic [4:0] S_EVAL  = 5'd4;
    localparam logic [4:0] S_P     = 5'd5;
    localparam logic [4:0] S_I     = 5'd6;
    localparam logic [4:0] S_D     = 5'd7;
    localparam logic [4:0] S_SUM   = 5'd8;
    localparam logic [4:0] S_DEC   = 5'd9;
    localparam logic [4:0] S_DEC2  = 5'd10;
    localparam logic [4:0] S_CLAMP = 5'd11;
    localparam logic [4:0] S_CORR  = 5'd12;
    localparam logic [4:0] S_L1    = 5'd13;
    localparam logic [4:0] S_L2    = 5'd14;
    localparam logic [4:0] S_L3    = 5'd15;
    localparam logic [4:0] S_FIN   = 5'd16;

    localparam logic signed [9:0]  DB   = 10'(DEADBAND);
    localparam logic signed [11:0] STEP = 12'(SLEW_STEP);

    t_cfg      cfg;
    t_ign_load ign;
    t_mul_a    mul_a;
    t_mul_b    mul_b;
    t_mul_p    r_prod;

    // sequencer and controller state
    logic [4:0]       r_state;
    logic [IGN_W-1:0] r_ign;
    logic             r_finished;
    logic             r_halt;
    logic             r_alert;
    logic signed [17:0] r_f;
    logic signed [8:0]  r_e1;
    logic signed [8:0]  r_e2;
    logic signed [15:0] r_accum;
    t_drive           r_cmd_l;
    t_drive           r_cmd_r;
    logic             r_out_valid;

    // working registers
    t_yaw               r_yaw;
    logic signed [8:0]  r_err;
    logic signed [8:0]  r_e;
    logic signed [25:0] r_acc;
    logic signed [9:0]  r_spd_l;
    logic signed [9:0]  r_spd_r;
    t_drive             r_ls;
    t_drive             r_rs;
    t_drive             r_out_l;
    t_drive             r_out_r;
    logic               r_out_stop;
    logic               r_out_alert;

    // step logic
    logic signed [17:0] head_sum;
    logic [8:0]         head_raw;
    logic [8:0]         heading;
    logic signed [10:0] err_raw;
    logic signed [10:0] err_wrap;
    logic signed [25:0] filt_sum;
    logic signed [17:0] f_bias;
    logic signed [9:0]  e_raw;
    logic signed [8:0]  e_dead;
    logic signed [9:0]  d1;
    logic signed [10:0] d2;
    logic signed [29:0] dec_p;
    logic signed [29:0] dec_bias;
    logic signed [25:0] lim;
    logic signed [25:0] acc_clamp;
    logic signed [15:0] acc_bias;
    logic signed [7:0]  corr;
    logic signed [9:0]  spd_l;
    logic signed [9:0]  spd_r;
    logic signed [9:0]  neg_l;
    logic signed [9:0]  neg_r;
    logic [8:0]         mag_l;
    logic [8:0]         mag_r;
    logic [8:0]         quot;
    logic [9:0]         biased;
    logic [9:0]         lim_l;
    logic [9:0]         lim_r;
    t_drive             shape_l;
    t_drive             shape_r;
    logic signed [11:0] cur_l;
    logic signed [11:0] cur_r;
    logic signed [11:0] tgt_l;
    logic signed [11:0] tgt_r;
    t_drive             slew_l;
    t_drive             slew_r;
    logic               take_in;
    logic               out_free;

    hhdd_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (i_cfg),
        .o_cfg      (cfg),
        .o_ign_load (ign)
    );

    hhdd_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (r_prod)
    );

    assign i_in.ready = (r_state == S_IDLE);
    assign take_in    = i_in.valid && i_in.ready && i_in.yaw_valid;
    assign out_free   = !r_out_valid || o_out.ready;

    // yaw rounded to whole degrees, negative yaw lifted by one turn first
    assign head_sum = 18'(r_yaw) + (r_yaw[YAW_W-1] ? 18'(WRAP_Q8) : 18'(HALF_Q8));
    assign head_raw = head_sum[16:8];
    assign heading  = (head_raw >= 9'd360) ? head_raw - 9'd360 : head_raw;

    // heading error wrapped to +-180
    assign err_raw = $signed({2'b00, cfg.target_heading}) - $signed({2'b00, heading});
    always_comb begin
        if (err_raw > 11'sd180) begin
            err_wrap = err_raw - 11'sd360;
        end else if (err_raw < -11'sd180) begin
            err_wrap = err_raw + 11'sd360;
        end else begin
            err_wrap = err_raw;
        end
    end

    // filter: accumulated keep term plus err*77 shifted to q16, floor back to q8
    assign filt_sum = r_acc + $signed({{2{r_prod[15]}}, r_prod[15:0], 8'b0});

    // whole error truncated toward zero, then deadband
    assign f_bias = r_f + (r_f[17] ? 18'sd255 : 18'sd0);
    assign e_raw  = f_bias[17:8];
    assign e_dead = (e_raw < DB && e_raw > -DB) ? 9'sd0 : e_raw[8:0];

    assign d1 = 10'(r_e) - 10'(r_e1);
    assign d2 = 11'(r_e) - (11'(r_e1) <<< 1) + 11'(r_e2);

    // decay product truncated toward zero
    assign dec_p    = r_prod[29:0];
    assign dec_bias = dec_p + (dec_p[29] ? 30'sd255 : 30'sd0);

    assign lim = $signed({11'b0, cfg.pid_max, 8'b0});
    always_comb begin
        if (r_acc > lim) begin
            acc_clamp = lim;
        end else if (r_acc < -lim) begin
            acc_clamp = -lim;
        end else begin
            acc_clamp = r_acc;
        end
    end

    // whole correction and the two wheel speeds
    assign acc_bias = r_accum + (r_accum[15] ? 16'sd255 : 16'sd0);
    assign corr     = acc_bias[15:8];
    assign spd_l    = $signed({2'b00, cfg.base_speed}) - 10'(corr);
    assign spd_r    = $signed({2'b00, cfg.base_speed}) + 10'(corr);

    assign neg_l = -r_spd_l;
    assign neg_r = -r_spd_r;
    assign mag_l = r_spd_l[9] ? neg_l[8:0] : r_spd_l[8:0];
    assign mag_r = r_spd_r[9] ? neg_r[8:0] : r_spd_r[8:0];

    // left: |speed|*13/10 with bias away from zero, right: speed as is; both clamped
    assign quot   = r_prod[24:16];
    assign biased = (quot == 9'd0) ? 10'd0 : {1'b0, quot} + 10'(LEFT_BIAS);
    assign lim_l  = (biased > cfg.drive_limit) ? cfg.drive_limit : biased;
    assign lim_r  = ({1'b0, mag_r} > cfg.drive_limit) ? cfg.drive_limit : {1'b0, mag_r};
    assign shape_l = r_spd_l[9] ? -$signed({1'b0, lim_l}) : $signed({1'b0, lim_l});
    assign shape_r = r_spd_r[9] ? -$signed({1'b0, lim_r}) : $signed({1'b0, lim_r});

    // slew toward the shaped commands
    assign cur_l = 12'(r_cmd_l);
    assign cur_r = 12'(r_cmd_r);
    assign tgt_l = 12'(r_ls);
    assign tgt_r = 12'(r_rs);
    always_comb begin
        if (cur_l < tgt_l - STEP) begin
            slew_l = DRIVE_W'(cur_l + STEP);
        end else if (cur_l > tgt_l + STEP) begin
            slew_l = DRIVE_W'(cur_l - STEP);
        end else begin
            slew_l = r_ls;
        end
        if (cur_r < tgt_r - STEP) begin
            slew_r = DRIVE_W'(cur_r + STEP);
        end else if (cur_r > tgt_r + STEP) begin
            slew_r = DRIVE_W'(cur_r - STEP);
        end else begin
            slew_r = r_rs;
        end
    end

    // operand select for the shared multiplier
    always_comb begin
        case (r_state)
            S_ERR: begin
                mul_a = MUL_A_W'(r_f);
                mul_b = MUL_B_W'(FILT_KEEP);
            end
            S_FILT1: begin
                mul_a = MUL_A_W'(r_err);
                mul_b = MUL_B_W'(FILT_TAKE);
            end
            S_P: begin
                mul_a = MUL_A_W'(d1);
                mul_b = $signed({4'b0, cfg.gain_p});
            end
            S_I: begin
                mul_a = MUL_A_W'(r_e);
                mul_b = $signed({4'b0, cfg.gain_i});
            end
            S_D: begin
                mul_a = MUL_A_W'(d2);
                mul_b = $signed({4'b0, cfg.gain_d});
            end
            S_DEC: begin
                mul_a = r_acc[MUL_A_W-1:0];
                mul_b = MUL_B_W'(DECAY_MUL);
            end
            S_L1: begin
                mul_a = $signed({15'b0, mag_l});
                mul_b = MUL_B_W'(LEFT_NUM);
            end
            S_L2: begin
                mul_a = $signed({11'b0, r_prod[12:0]});
                mul_b = MUL_B_W'(RECIP_10);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // sequencer and controller state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ign       <= IGN_W'(IGNORE_INIT);
            r_finished  <= 1'b0;
            r_halt      <= 1'b0;
            r_alert     <= 1'b0;
            r_f         <= '0;
            r_e1        <= '0;
            r_e2        <= '0;
            r_accum     <= '0;
            r_cmd_l     <= '0;
            r_cmd_r     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (take_in) begin
                        r_halt  <= 1'b0;
                        r_alert <= 1'b0;
                        r_state <= S_ERR;
                        if (r_finished) begin
                            // stop latched: zero drive, controller held clear
                            r_f     <= '0;
                            r_e1    <= '0;
                            r_e2    <= '0;
                            r_accum <= '0;
                            r_cmd_l <= '0;
                            r_cmd_r <= '0;
                            r_halt  <= 1'b1;
                            r_state <= S_FIN;
                        end else if (r_ign != '0) begin
                            r_ign <= r_ign - 1'b1;
                        end else if (i_in.line_bits != '0) begin
                            // end line seen: latch stop and flag this word
                            r_f        <= '0;
                            r_e1       <= '0;
                            r_e2       <= '0;
                            r_accum    <= '0;
                            r_cmd_l    <= '0;
                            r_cmd_r    <= '0;
                            r_finished <= 1'b1;
                            r_halt     <= 1'b1;
                            r_alert    <= 1'b1;
                            r_state    <= S_FIN;
                        end
                    end
                end
                S_ERR:   r_state <= S_FILT1;
                S_FILT1: r_state <= S_FILT2;
                S_FILT2: begin
                    r_f     <= filt_sum[25:8];
                    r_state <= S_EVAL;
                end
                S_EVAL:  r_state <= S_P;
                S_P:     r_state <= S_I;
                S_I:     r_state <= S_D;
                S_D:     r_state <= S_SUM;
                S_SUM:   r_state <= S_DEC;
                S_DEC:   r_state <= S_DEC2;
                S_DEC2:  r_state <= S_CLAMP;
                S_CLAMP: begin
                    r_accum <= acc_clamp[15:0];
                    r_e2    <= r_e1;
                    r_e1    <= r_e;
                    r_state <= S_CORR;
                end
                S_CORR:  r_state <= S_L1;
                S_L1:    r_state <= S_L2;
                S_L2:    r_state <= S_L3;
                S_L3:    r_state <= S_FIN;
                S_FIN: begin
                    if (out_free) begin
                        if (!r_halt) begin
                            r_cmd_l <= slew_l;
                            r_cmd_r <= slew_r;
                        end
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
            // register write reloads the live ignore count
            if (ign.load) begin
                r_ign <= ign.value;
            end
        end
    end

    // working registers and output word
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE:  r_yaw <= i_in.yaw_angle;
            S_ERR:   r_err <= err_wrap[8:0];
            S_FILT1: r_acc <= $signed(r_prod[25:0]);
            S_EVAL:  r_e   <= e_dead;
            S_I:     r_acc <= $signed(r_prod[25:0]);
            S_D:     r_acc <= r_acc + $signed(r_prod[25:0]);
            S_SUM:   r_acc <= r_acc + $signed(r_prod[25:0]) + 26'(r_accum);
            S_DEC2: begin
                // decay only when the whole error is zero
                if (r_e == 9'sd0) begin
                    r_acc <= 26'($signed(dec_bias[29:8]));
                end
            end
            S_CORR: begin
                r_spd_l <= spd_l;
                r_spd_r <= spd_r;
            end
            S_L3: begin
                r_ls <= shape_l;
                r_rs <= shape_r;
            end
            S_FIN: begin
                if (out_free) begin
                    r_out_l     <= r_halt ? '0 : slew_l;
                    r_out_r     <= r_halt ? '0 : slew_r;
                    r_out_stop  <= r_finished;
                    r_out_alert <= r_alert;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.left_drive  = r_out_l;
    assign o_out.right_drive = r_out_r;
    assign o_out.stopped     = r_out_stop;
    assign o_out.alert_start = r_out_alert;

endmodule

### verif/heading_hold_differential_drive_test.sv
// testbench: heading hold controller checked against a per-tick predictor under random pacing
module heading_hold_differential_drive_test;
    timeunit 1ns;
    timeprecision 1ps;

    import hhdd_pkg::*;

    // clocking, pacing and run length
    localparam int CLK_HALF      = 6;
    localparam int RESET_CYCLES  = 9;
    localparam int MAX_GAP       = 6;
    localparam int LONG_HOLD     = 400;
    localparam int SETTLE_CYCLES = 40;
    localparam int CYCLE_LIMIT   = 400000;

    // arithmetic of the controller
    localparam int Q8         = 256;
    localparam int Q8_SHIFT   = 8;
    localparam int FULL_TURN  = 360;
    localparam int HALF_TURN  = 180;
    localparam int YAW_SPAN   = 46080;
    localparam int PCT        = 100;
    localparam int LEFT_PCT   = 130;
    localparam int RIGHT_PCT  = 100;
    localparam int RIGHT_BIAS = 0;

    // register values after reset
    localparam int RST_BASE    = 30;
    localparam int RST_LIMIT   = 100;
    localparam int RST_GAIN_P  = 46;
    localparam int RST_GAIN_I  = 0;
    localparam int RST_GAIN_D  = 77;
    localparam int RST_PID_MAX = 12;

    typedef struct packed {
        t_drive left;
        t_drive right;
        logic   stopped;
        logic   alert;
    } t_drive_word;

    // predicts the drive word of every accepted tick with a valid yaw and checks what comes out
    class heading_hold_scoreboard;
        int target_deg, base_speed, ignore_ticks, drive_limit;
        int gain_p, gain_i, gain_d, pid_max;
        int left_cmd, right_cmd;
        int err_filt, err_last, err_prev, corr_acc;
        int ign_count;
        bit finished;
        int errors;
        t_drive_word drive_words_due[$];

        function new();
            target_deg   = 0;
            base_speed   = RST_BASE;
            ignore_ticks = IGNORE_INIT;
            drive_limit  = RST_LIMIT;
            gain_p       = RST_GAIN_P;
            gain_i       = RST_GAIN_I;
            gain_d       = RST_GAIN_D;
            pid_max      = RST_PID_MAX;
            left_cmd     = 0;
            right_cmd    = 0;
            clear_loop();
            ign_count    = ignore_ticks;
            finished     = 1'b0;
            errors       = 0;
        endfunction

        function void clear_loop();
            err_filt = 0;
            err_last = 0;
            err_prev = 0;
            corr_acc = 0;
        endfunction

        function int pending();
            return drive_words_due.size();
        endfunction

        function void write_reg(t_cfg_idx idx, t_cfg_data d);
            case (idx)
                REG_TARGET: begin
                    target_deg = int'(d[8:0]);
                end
                REG_BASE: begin
                    base_speed = int'(d[7:0]);
                end
                REG_IGNORE: begin
                    // loading the register also restarts the count
                    ignore_ticks = int'(d);
                    ign_count    = ignore_ticks;
                end
                REG_LIMIT: begin
                    drive_limit = int'(d[9:0]);
                end
                REG_GAIN_P: begin
                    gain_p = int'(d[9:0]);
                end
                REG_GAIN_I: begin
                    gain_i = int'(d[9:0]);
                end
                REG_GAIN_D: begin
                    gain_d = int'(d[9:0]);
                end
                REG_PID_MAX: begin
                    pid_max = int'(d[6:0]);
                end
                default: ;
            endcase
        endfunction

        function int clamp_sym(int x, int lim);
            if (x > lim) return lim;
            if (x < -lim) return -lim;
            return x;
        endfunction

        function int slew_to(int cur, int tgt);
            if (cur < tgt - SLEW_STEP) return cur + SLEW_STEP;
            if (cur > tgt + SLEW_STEP) return cur - SLEW_STEP;
            return tgt;
        endfunction

        function int wheel_speed(int speed, int pct, int bias);
            int s;
            s = (speed * pct) / PCT;
            if (s > 0) s += bias;
            else if (s < 0) s -= bias;
            return clamp_sym(s, drive_limit);
        endfunction

        // steering correction in whole units after one pid update
        function int steer_correction(int yaw_q8);
            int heading, err, e, delta, acc;
            if (yaw_q8 < 0) heading = (yaw_q8 + WRAP_Q8) / Q8;
            else heading = (yaw_q8 + HALF_Q8) / Q8;
            if (heading >= FULL_TURN) heading -= FULL_TURN;

            err = target_deg - heading;
            if (err > HALF_TURN) err -= FULL_TURN;
            else if (err < -HALF_TURN) err += FULL_TURN;

            // floor of the q8 filter sum, arithmetic shift on a signed int
            err_filt = (err_filt * FILT_KEEP + err * FILT_TAKE * Q8) >>> Q8_SHIFT;
            e = err_filt / Q8;
            if (e < DEADBAND && e > -DEADBAND) e = 0;

            delta = gain_p * (e - err_last) + gain_i * e
                  + gain_d * (e - 2 * err_last + err_prev);
            acc = corr_acc + delta;
            if (e == 0) acc = (acc * DECAY_MUL) / Q8;
            corr_acc = clamp_sym(acc, pid_max * Q8);

            err_prev = err_last;
            err_last = e;
            return corr_acc / Q8;
        endfunction

        function void note_tick(t_yaw yaw, logic yaw_ok, t_line line);
            int corr;
            bit alert;
            t_drive_word w;
            if (!yaw_ok) return;
            alert = 1'b0;
            if (finished) begin
                clear_loop();
                left_cmd  = 0;
                right_cmd = 0;
            end else if (ign_count > 0) begin
                ign_count--;
            end else if (line != '0) begin
                clear_loop();
                left_cmd  = 0;
                right_cmd = 0;
                finished  = 1'b1;
                alert     = 1'b1;
            end
            if (!finished) begin
                corr      = steer_correction(int'(yaw));
                left_cmd  = slew_to(left_cmd, wheel_speed(base_speed - corr, LEFT_PCT, LEFT_BIAS));
                right_cmd = slew_to(right_cmd,
                                    wheel_speed(base_speed + corr, RIGHT_PCT, RIGHT_BIAS));
            end
            w.left    = t_drive'(left_cmd);
            w.right   = t_drive'(right_cmd);
            w.stopped = finished;
            w.alert   = alert;
            drive_words_due.push_back(w);
        endfunction

        function void check_drive_word(t_drive l, t_drive r, logic s, logic a);
            t_drive_word want;
            if (drive_words_due.size() == 0) begin
                $error("drive word with nothing due: left %0d right %0d", l, r);
                errors++;
                return;
            end
            want = drive_words_due.pop_front();
            if (l !== want.left) begin
                $error("left_drive expected %0d got %0d", want.left, l);
                errors++;
            end
            if (r !== want.right) begin
                $error("right_drive expected %0d got %0d", want.right, r);
                errors++;
            end
            if (s !== want.stopped) begin
                $error("stopped expected %0b got %0b", want.stopped, s);
                errors++;
            end
            if (a !== want.alert) begin
                $error("alert_start expected %0b got %0b", want.alert, a);
                errors++;
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    hhdd_in_if  tick_ch ();
    hhdd_out_if drive_ch ();
    hhdd_cfg_if cfg_ch ();

    heading_hold_differential_drive u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (tick_ch),
        .o_out   (drive_ch),
        .i_cfg   (cfg_ch)
    );

    heading_hold_scoreboard sb;

    // pacing controls shared by the sender and the receiver
    bit pace_free     = 1'b0;
    bit long_hold_req = 1'b0;
    int yaw_track     = 0;
    int unsigned cycle_count = 0;

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // watchdog on the whole run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("heading_hold_differential_drive_test failed");
            $finish;
        end
    end

    // sample both channels at the rising edge: accepted tick words feed the predictor,
    // accepted drive words are checked against the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1) begin
            if (tick_ch.valid && tick_ch.ready)
                sb.note_tick(tick_ch.yaw_angle, tick_ch.yaw_valid, tick_ch.line_bits);
            if (drive_ch.valid && drive_ch.ready)
                sb.check_drive_word(drive_ch.left_drive, drive_ch.right_drive,
                                    drive_ch.stopped, drive_ch.alert_start);
        end
    end

    // receiver: random stall before each drive word, one long hold on request
    initial begin : drive_sink
        int gap;
        drive_ch.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            if (long_hold_req) begin
                // long hold counted here so the block backs up into its input
                gap = LONG_HOLD;
                long_hold_req = 1'b0;
            end else begin
                gap = pace_free ? 0 : $urandom_range(0, MAX_GAP);
            end
            if (gap > 0) begin
                drive_ch.ready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            drive_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (!(drive_ch.valid && drive_ch.ready)) @(posedge i_clk);
            @(negedge i_clk);
        end
    end

    // one tick word: optional gap, then hold valid until accepted
    task automatic send_tick(t_yaw yaw, logic yaw_ok, t_line line);
        int gap;
        gap = pace_free ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            tick_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        tick_ch.valid     <= 1'b1;
        tick_ch.yaw_angle <= yaw;
        tick_ch.yaw_valid <= yaw_ok;
        tick_ch.line_bits <= line;
        @(posedge i_clk);
        while (!tick_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // sender pauses until every predicted drive word has come back
    task automatic wait_drained();
        tick_ch.valid <= 1'b0;
        @(negedge i_clk);
        while (sb.pending() != 0) @(negedge i_clk);
    endtask

    // drained plus slack for a tick that makes no word but may still be in flight
    task automatic settle();
        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic cfg_write(t_cfg_idx idx, int value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= t_cfg_data'(value);
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        sb.write_reg(idx, t_cfg_data'(value));
        @(negedge i_clk);
    endtask

    task automatic apply_settings(int tgt, int base, int ign, int lim,
                                  int gp, int gi, int gd, int pmax);
        cfg_write(REG_TARGET, tgt);
        cfg_write(REG_BASE, base);
        cfg_write(REG_IGNORE, ign);
        cfg_write(REG_LIMIT, lim);
        cfg_write(REG_GAIN_P, gp);
        cfg_write(REG_GAIN_I, gi);
        cfg_write(REG_GAIN_D, gd);
        cfg_write(REG_PID_MAX, pmax);
        cfg_ch.valid <= 1'b0;
        @(negedge i_clk);
    endtask

    // mild keeps the gains low so the loop settles and the deadband gets used
    task automatic apply_random_settings(bit mild, bit wide_target);
        int tgt, gmax;
        tgt  = wide_target ? $urandom_range(FULL_TURN, 511) : $urandom_range(0, FULL_TURN - 1);
        gmax = mild ? 120 : 1023;
        apply_settings(tgt, $urandom_range(0, 255), $urandom_range(0, 30),
                       $urandom_range(0, 1023), $urandom_range(0, gmax),
                       $urandom_range(0, gmax / 4), $urandom_range(0, gmax),
                       $urandom_range(0, 127));
    endtask

    // random ticks: mostly a yaw wandering around the target, some spread over the
    // full range, some raw 17 bit noise; a line is shown only while it is ignored,
    // on dropped ticks, or from finish_from on in the closing phase
    task automatic run_random(int count, bit hold, bit drain, int finish_from);
        int k, r, h, aim_yaw_q8;
        t_yaw yaw;
        logic yaw_ok;
        t_line line;
        h = sb.target_deg % FULL_TURN;
        aim_yaw_q8 = (h > HALF_TURN ? h - FULL_TURN : h) * Q8;
        yaw_track = aim_yaw_q8;
        if (hold) long_hold_req = 1'b1;
        for (k = 0; k < count; k++) begin
            if (drain && k == count / 2) wait_drained();
            yaw_ok = ($urandom_range(0, 9) != 0);
            r = $urandom_range(0, 99);
            if (r < 55) begin
                if ($urandom_range(0, 19) == 0)
                    yaw_track = aim_yaw_q8 + int'($urandom_range(0, 4096)) - 2048;
                else
                    yaw_track += int'($urandom_range(0, 1536)) - 768;
                if (yaw_track > YAW_SPAN) yaw_track = YAW_SPAN;
                if (yaw_track < -YAW_SPAN) yaw_track = -YAW_SPAN;
                yaw = t_yaw'(yaw_track);
            end else if (r < 85) begin
                yaw = t_yaw'(int'($urandom_range(0, 2 * YAW_SPAN)) - YAW_SPAN);
            end else begin
                yaw = t_yaw'($urandom);
            end
            if (!yaw_ok || sb.ign_count > 0 || (finish_from >= 0 && k >= finish_from))
                line = t_line'($urandom);
            else
                line = '0;
            send_tick(yaw, yaw_ok, line);
        end
    endtask

    initial begin
        sb = new();
        i_rst_n           = 1'b0;
        tick_ch.valid     = 1'b0;
        tick_ch.yaw_angle = '0;
        tick_ch.yaw_valid = 1'b0;
        tick_ch.line_bits = '0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.index      = REG_TARGET;
        cfg_ch.data       = '0;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed ticks on reset settings; the line is still being ignored here
        send_tick(t_yaw'(0), 1'b1, 8'h00);
        send_tick(t_yaw'(YAW_SPAN), 1'b1, 8'h01);        // +180, line ignored
        send_tick(t_yaw'(-YAW_SPAN), 1'b1, 8'h80);       // -180
        send_tick(t_yaw'(-65536), 1'b1, 8'hff);          // most negative raw yaw
        send_tick(t_yaw'(65535), 1'b1, 8'h55);           // most positive raw yaw
        send_tick(t_yaw'(127), 1'b1, 8'haa);             // just below half a degree
        send_tick(t_yaw'(128), 1'b1, 8'h00);             // rounds up
        send_tick(t_yaw'(-128), 1'b1, 8'h00);            // rounds to 360, wraps to 0
        send_tick(t_yaw'(-129), 1'b1, 8'h00);
        send_tick(t_yaw'(23040), 1'b1, 8'h00);           // +90
        send_tick(t_yaw'(-23040), 1'b1, 8'h00);          // -90
        send_tick(t_yaw'(0), 1'b0, 8'hff);               // dropped tick
        send_tick(t_yaw'(12345), 1'b0, 8'h00);           // dropped tick
        // small errors around the deadband, then zero error for the decay
        send_tick(t_yaw'(256), 1'b1, 8'h00);
        send_tick(t_yaw'(384), 1'b1, 8'h00);
        send_tick(t_yaw'(-256), 1'b1, 8'h00);
        send_tick(t_yaw'(-384), 1'b1, 8'h00);
        send_tick(t_yaw'(768), 1'b1, 8'h00);
        send_tick(t_yaw'(0), 1'b1, 8'h00);
        send_tick(t_yaw'(0), 1'b1, 8'h00);
        send_tick(t_yaw'(0), 1'b1, 8'h00);
        send_tick(t_yaw'(0), 1'b1, 8'h00);
        settle();

        // every register at its low end, no idling on either side
        pace_free = 1'b1;
        apply_settings(0, 0, 0, 0, 0, 0, 0, 0);
        run_random(150, 1'b0, 1'b0, -1);
        settle();
        pace_free = 1'b0;

        // every register at its top, with a long receiver hold
        apply_settings(511, 255, 65535, 1023, 1023, 1023, 1023, 127);
        run_random(150, 1'b1, 1'b0, -1);
        settle();

        // settings close to reset, sender pauses in the middle
        apply_settings(90, 30, 10, 100, 46, 0, 77, 12);
        run_random(250, 1'b0, 1'b1, -1);
        settle();

        pace_free = 1'b1;
        apply_random_settings(1'b1, 1'b0);
        run_random(220, 1'b1, 1'b0, -1);
        settle();
        pace_free = 1'b0;

        apply_random_settings(1'b0, 1'b0);
        run_random(220, 1'b0, 1'b0, -1);
        settle();

        // target beyond a full turn
        apply_random_settings(1'b1, 1'b1);
        run_random(220, 1'b0, 1'b1, -1);
        settle();

        apply_random_settings(1'b1, 1'b0);
        run_random(220, 1'b0, 1'b0, -1);
        settle();

        // closing phase: the end line latches the stop, later ticks stay stopped
        apply_random_settings(1'b1, 1'b0);
        run_random(200, 1'b0, 1'b0, 80);
        settle();

        if (sb.errors == 0 && sb.pending() == 0)
            $display("heading_hold_differential_drive_test passed");
        else
            $display("heading_hold_differential_drive_test failed");
        $finish;
    end

endmodule
